/* design/m3i_pkg.sv */
// Shared constants and cofactor index table for the 3x3 matrix inverse.
`timescale 1ns / 1ps
package m3i_pkg;

  localparam int ELEM_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int NUM_ELEMS      = 9;

  // Element indexes per adjugate entry: adj = e[i0]*e[i1] - e[i2]*e[i3].
  localparam logic [3:0] COF_IDX [NUM_ELEMS][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
  };

endpackage

/* design/m3i_if.sv */
// Request channel interfaces for matrix input and inverse output.
`timescale 1ns / 1ps
interface m3i_in_if #(parameter int W = 32);
  logic valid;
  logic ready;
  logic signed [W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  input ready);
  modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  output ready);
endinterface

interface m3i_out_if #(parameter int W = 32);
  logic valid;
  logic ready;
  logic signed [W-1:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
  logic signed [W-1:0] determinant;
  logic singular;
  modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20,
                  inv21, inv22, determinant, singular, input ready);
  modport sink   (input valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20,
                  inv21, inv22, determinant, singular, output ready);
endinterface

/* design/m3i_lane.sv */
// One inverse lane: cofactor, then a pipelined restoring divide by the determinant.
`timescale 1ns / 1ps
module m3i_lane import m3i_pkg::*; #(
  parameter int W = ELEM_WIDTH_DEF,
  parameter int F = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  input  logic signed [W-1:0]   c_i,
  input  logic signed [W-1:0]   d_i,
  output logic signed [2*W:0]   adj_o,
  input  logic signed [3*W+1:0] det_i,
  output logic signed [W-1:0]   inv_o
);

  localparam int PW  = 2 * W;
  localparam int CW  = 2 * W + 1;
  localparam int DW  = 3 * W + 2;
  localparam int NW  = 2 * W + 2 * F;
  localparam int RW  = ((NW > DW + W) ? NW : DW + W) + 1;

  logic signed [PW-1:0] p_q, q_q;
  logic signed [CW-1:0] adj_q, adj3_q, adj4_q;
  logic [CW-1:0]        amag;
  logic [DW-1:0]        dmag;
  logic [NW-1:0]        num_q;
  logic [DW-1:0]        den5_q;
  logic                 neg5_q, sing5_q;

  logic [RW-1:0] rem_q  [W+1];
  logic [W-1:0]  quo_q  [W+1];
  logic [DW-1:0] den_q  [W+1];
  logic          ovf_q  [W+1];
  logic          neg_q  [W+1];
  logic          sing_q [W+1];

  logic signed [W-1:0] inv_q, inv_d;
  logic [W-1:0]        qf;
  logic [W-1:0]        lim;

  assign adj_o = adj_q;
  assign amag  = adj4_q[CW-1] ? CW'(-adj4_q) : CW'(adj4_q);
  assign dmag  = det_i[DW-1] ? DW'(-det_i) : DW'(det_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q     <= a_i * b_i;
      q_q     <= c_i * d_i;
      adj_q   <= CW'(p_q) - CW'(q_q);
      adj3_q  <= adj_q;
      adj4_q  <= adj3_q;
      num_q   <= NW'(amag) << (2 * F);
      den5_q  <= dmag;
      neg5_q  <= adj4_q[CW-1] ^ det_i[DW-1];
      sing5_q <= (det_i == '0);
      rem_q[0]  <= RW'(num_q);
      quo_q[0]  <= '0;
      den_q[0]  <= den5_q;
      ovf_q[0]  <= (RW'(num_q) >= (RW'(den5_q) << W));
      neg_q[0]  <= neg5_q;
      sing_q[0] <= sing5_q;
      inv_q     <= inv_d;
    end
  end

  for (genvar s = 1; s <= W; s++) begin : g_div
    localparam int K = W - s;
    logic [RW-1:0] sub;
    logic          take;
    assign sub  = RW'(den_q[s-1]) << K;
    assign take = (rem_q[s-1] >= sub);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= take ? rem_q[s-1] - sub : rem_q[s-1];
        quo_q[s]  <= quo_q[s-1] | (W'(take) << K);
        den_q[s]  <= den_q[s-1];
        ovf_q[s]  <= ovf_q[s-1];
        neg_q[s]  <= neg_q[s-1];
        sing_q[s] <= sing_q[s-1];
      end
    end
  end

  always_comb begin
    qf  = quo_q[W];
    lim = W'(1) << (W - 1);
    if (sing_q[W]) begin
      inv_d = '0;
    end else if (!neg_q[W]) begin
      inv_d = (ovf_q[W] || qf > lim - W'(1)) ? $signed(lim - W'(1)) : $signed(qf);
    end else begin
      inv_d = (ovf_q[W] || qf > lim) ? $signed(lim) : $signed(W'(-qf));
    end
  end

  assign inv_o = inv_q;

endmodule

/* design/m3i_det.sv */
// Determinant merge: first-row expansion over the lane cofactors, rescaled and saturated.
`timescale 1ns / 1ps
module m3i_det import m3i_pkg::*; #(
  parameter int W = ELEM_WIDTH_DEF,
  parameter int F = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [W-1:0]   e_i   [3],
  input  logic signed [2*W:0]   adj_i [3],
  output logic signed [3*W+1:0] det_o,
  output logic signed [W-1:0]   dout_o,
  output logic                  sing_o
);

  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 2;
  localparam int MW = 2 * W + 1;

  logic signed [W-1:0]  e1_q [3];
  logic signed [W-1:0]  e2_q [3];
  logic signed [MW-1:0] lo_q [3];
  logic signed [MW-1:0] hi_q [3];
  logic signed [DW-1:0] det_q, det_d;
  logic [DW-1:0]        mag, sh, lim;
  logic signed [W-1:0]  dout_q, dout_d;
  logic                 sing_q;

  always_comb begin
    det_d = '0;
    for (int j = 0; j < 3; j++) begin
      det_d = det_d + (DW'(hi_q[j]) <<< W) + DW'(lo_q[j]);
    end
  end

  always_comb begin
    mag = det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
    sh  = mag >> (2 * F);
    lim = DW'(1) << (W - 1);
    if (!det_q[DW-1]) begin
      dout_d = (sh > lim - DW'(1)) ? W'(lim - DW'(1)) : W'(sh);
    end else begin
      dout_d = (sh > lim) ? W'(-lim) : W'(-sh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        e1_q[j] <= e_i[j];
        e2_q[j] <= e1_q[j];
        lo_q[j] <= e2_q[j] * $signed({1'b0, adj_i[j][W-1:0]});
        hi_q[j] <= e2_q[j] * $signed(adj_i[j][CW-1:W]);
      end
      det_q  <= det_d;
      dout_q <= dout_d;
      sing_q <= (det_q == '0);
    end
  end

  assign det_o  = det_q;
  assign dout_o = dout_q;
  assign sing_o = sing_q;

endmodule

/* design/matrix3x3_inverse.sv */
// Top level of the pipelined 3x3 fixed-point matrix inverse.
`timescale 1ns / 1ps
// Accepts one 3x3 signed fixed-point matrix per cycle unless stalled and returns
// its inverse (adjugate over determinant, truncated toward zero, saturated) plus
// the determinant and a singular flag; a singular matrix gives zero inverse
// entries. Throughput is one request per cycle while the output does not stall.
// The nine lane dividers resolve one quotient bit per pipeline stage after the
// cofactor, determinant and overflow-check stages. The whole pipeline holds
// while the output request waits, so a stalled result never blocks in place of
// a new one for longer than that stall.
module matrix3x3_inverse import m3i_pkg::*; #(
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  m3i_in_if.sink      in_i,
  m3i_out_if.source   out_o
);

  localparam int W   = ELEM_WIDTH;
  localparam int DW  = 3 * W + 2;
  localparam int LAT = W + 7;

  logic                  en;
  logic [LAT-1:0]        vld_q;
  logic signed [W-1:0]   elem [NUM_ELEMS];
  logic signed [2*W:0]   adj  [NUM_ELEMS];
  logic signed [W-1:0]   inv  [NUM_ELEMS];
  logic signed [W-1:0]   e_row [3];
  logic signed [2*W:0]   adj_col [3];
  logic signed [DW-1:0]  det;
  logic signed [W-1:0]   dout;
  logic                  sing;
  logic signed [W-1:0]   dd_q [W+2];
  logic                  sd_q [W+2];

  assign elem[0] = in_i.a00;
  assign elem[1] = in_i.a01;
  assign elem[2] = in_i.a02;
  assign elem[3] = in_i.a10;
  assign elem[4] = in_i.a11;
  assign elem[5] = in_i.a12;
  assign elem[6] = in_i.a20;
  assign elem[7] = in_i.a21;
  assign elem[8] = in_i.a22;

  assign en         = !vld_q[LAT-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  for (genvar k = 0; k < NUM_ELEMS; k++) begin : g_lane
    m3i_lane #(.W(W), .F(FRAC_BITS)) u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (elem[COF_IDX[k][0]]),
      .b_i   (elem[COF_IDX[k][1]]),
      .c_i   (elem[COF_IDX[k][2]]),
      .d_i   (elem[COF_IDX[k][3]]),
      .adj_o (adj[k]),
      .det_i (det),
      .inv_o (inv[k])
    );
  end

  assign e_row[0]   = elem[0];
  assign e_row[1]   = elem[1];
  assign e_row[2]   = elem[2];
  assign adj_col[0] = adj[0];
  assign adj_col[1] = adj[3];
  assign adj_col[2] = adj[6];

  m3i_det #(.W(W), .F(FRAC_BITS)) u_det (
    .clk_i  (clk_i),
    .en_i   (en),
    .e_i    (e_row),
    .adj_i  (adj_col),
    .det_o  (det),
    .dout_o (dout),
    .sing_o (sing)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      dd_q[0] <= dout;
      sd_q[0] <= sing;
      for (int n = 1; n < W + 2; n++) begin
        dd_q[n] <= dd_q[n-1];
        sd_q[n] <= sd_q[n-1];
      end
    end
  end

  assign out_o.valid       = vld_q[LAT-1];
  assign out_o.inv00       = inv[0];
  assign out_o.inv01       = inv[1];
  assign out_o.inv02       = inv[2];
  assign out_o.inv10       = inv[3];
  assign out_o.inv11       = inv[4];
  assign out_o.inv12       = inv[5];
  assign out_o.inv20       = inv[6];
  assign out_o.inv21       = inv[7];
  assign out_o.inv22       = inv[8];
  assign out_o.determinant = dd_q[W+1];
  assign out_o.singular    = sd_q[W+1];

endmodule
